// File: rtl/btum_pkg.sv
// ----------------------------------------------------------------------------
// btum_pkg
// Shared types and constants of the busy-time utilization monitor.
// ----------------------------------------------------------------------------
package btum_pkg;

  localparam int unsigned OUT_W      = 48;  // width of the time words on the ports
  localparam int unsigned PERIOD_W   = 32;  // width of the window length register
  localparam int unsigned HUND_W     = 14;  // width of the busy share word
  localparam int unsigned SCALE_BITS = 15;  // bits of the 2 x 10000 scale
  localparam int unsigned QUO_W      = 16;  // scaled quotient, holds up to 20000
  localparam int unsigned CNT_W      = 4;   // indexes SCALE_BITS bits

  localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 32'd60000000;
  localparam logic [SCALE_BITS-1:0] SCALE2       = 15'd20000;
  localparam logic [HUND_W-1:0]     HUND_FULL    = 14'd10000;

  // Event kinds
  localparam logic CMD_WAIT_START = 1'b0;
  localparam logic CMD_WAIT_END   = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DIFF     = 9'b000000010,
    ST_ACCUM    = 9'b000000100,
    ST_REPORT   = 9'b000001000,
    ST_CLASSIFY = 9'b000010000,
    ST_DBL      = 9'b000100000,
    ST_ADD      = 9'b001000000,
    ST_FINISH   = 9'b010000000,
    ST_OUT      = 9'b100000000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming word
    logic diff;      // form clamped time difference and window end
    logic accum;     // fold the difference into its sum, update timestamps
    logic report;    // snapshot sums, clear them, advance the window
    logic classify;  // handle zero / full share, prime the divider
    logic dbl;       // divider: remainder doubling step
    logic add;       // divider: add busy step
    logic finish;    // round the quotient into the share word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_stop;    // current word is a wait end
    logic due;        // window has closed before this timestamp
    logic trivial;    // share known without dividing
    logic scale_bit;  // scale bit at the current divider position
    logic last_bit;   // divider at its last position
  } sts_t;

endpackage

// File: rtl/busy_time_utilization_monitor.sv
// ----------------------------------------------------------------------------
// busy_time_utilization_monitor
// Accumulates busy and wait time from wait start / wait end words and emits
// a utilization report when a wait end word arrives after the window closed.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i/in_ready_o  | command_i, timestamp_us_i
//  out     | output    | out_valid_o/out_ready_i| wait/busy/elapsed_time_us_o,
//          |           |                        | busy_hundredths_o
//  cfg     | input     | cfg_we_i (no stall)    | cfg_wdata_i (report period)
//
//  - A word that raises no report passes through accept, time difference and
//    window end, and accumulate; in_ready_o returns after that.
//  - A report adds a snapshot step, a classify step, the share divider
//    (one add-mod step per cycle: 15 doubling steps plus 5 add steps for the
//    set bits of 20000) and a rounding step before out_valid_o.
//    A zero elapsed time or a full share skips the divider.
//  - One word in flight; in_ready_o is low until any raised report is taken.
//  - Reset clears timestamps, sums and window; period resets to 60 s.
//  - out_valid_o holds with a stable report until out_ready_i.
// ----------------------------------------------------------------------------
module busy_time_utilization_monitor #(
  parameter int unsigned TIME_WIDTH = 48  // internal time width, 32 to 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [btum_pkg::PERIOD_W-1:0]     cfg_wdata_i,
  // event words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [btum_pkg::OUT_W-1:0]        timestamp_us_i,
  // report words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [btum_pkg::OUT_W-1:0]        wait_time_us_o,
  output logic [btum_pkg::OUT_W-1:0]        busy_time_us_o,
  output logic [btum_pkg::OUT_W-1:0]        elapsed_time_us_o,
  output logic [btum_pkg::HUND_W-1:0]       busy_hundredths_o
);

  btum_pkg::cmd_t cmd;
  btum_pkg::sts_t sts;

  // Sequencer: one word at a time, divider steps under its control
  btum_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Time bookkeeping, report registers and shared add-mod divider
  btum_dp #(
    .TW (TIME_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .command_i         (command_i),
    .timestamp_us_i    (timestamp_us_i),
    .wait_time_us_o    (wait_time_us_o),
    .busy_time_us_o    (busy_time_us_o),
    .elapsed_time_us_o (elapsed_time_us_o),
    .busy_hundredths_o (busy_hundredths_o)
  );

  // The block never accepts a word while a report is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("in_ready_o high while a report is pending");

  // An accepted word keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input reopened right after accept");

  // Share never exceeds 100.00 percent
  a_share_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (busy_hundredths_o <= btum_pkg::HUND_FULL))
    else $error("busy share out of range");

  // Elapsed covers busy time (saturating sum)
  a_elapsed_ge_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (elapsed_time_us_o >= busy_time_us_o))
    else $error("elapsed below busy time");

endmodule

// File: rtl/btum_ctrl.sv
// ----------------------------------------------------------------------------
// btum_ctrl
// Sequencer of the monitor: event update, report, and the share divider.
// ----------------------------------------------------------------------------
module btum_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  btum_pkg::sts_t sts_i,
  output btum_pkg::cmd_t cmd_o
);

  btum_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btum_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      btum_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = btum_pkg::ST_DIFF;
        end
      end
      btum_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = btum_pkg::ST_ACCUM;
      end
      btum_pkg::ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        if (sts_i.is_stop && sts_i.due) begin
          state_d = btum_pkg::ST_REPORT;
        end else begin
          state_d = btum_pkg::ST_IDLE;
        end
      end
      btum_pkg::ST_REPORT: begin
        cmd_o.report = 1'b1;
        state_d      = btum_pkg::ST_CLASSIFY;
      end
      btum_pkg::ST_CLASSIFY: begin
        cmd_o.classify = 1'b1;
        state_d = sts_i.trivial ? btum_pkg::ST_OUT : btum_pkg::ST_DBL;
      end
      btum_pkg::ST_DBL: begin
        cmd_o.dbl = 1'b1;
        priority if (sts_i.scale_bit) begin
          state_d = btum_pkg::ST_ADD;
        end else if (sts_i.last_bit) begin
          state_d = btum_pkg::ST_FINISH;
        end else begin
          state_d = btum_pkg::ST_DBL;
        end
      end
      btum_pkg::ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d = sts_i.last_bit ? btum_pkg::ST_FINISH : btum_pkg::ST_DBL;
      end
      btum_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = btum_pkg::ST_OUT;
      end
      btum_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = btum_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = btum_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == btum_pkg::ST_IDLE);
  assign out_valid_o = (state_q == btum_pkg::ST_OUT);

endmodule

// File: rtl/btum_dp.sv
// ----------------------------------------------------------------------------
// btum_dp
// Datapath: timestamps, saturating sums, window, report words and divider.
// ----------------------------------------------------------------------------
module btum_dp #(
  parameter int unsigned TW = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  btum_pkg::cmd_t                    cmd_i,
  output btum_pkg::sts_t                    sts_o,
  input  logic                              cfg_we_i,
  input  logic [btum_pkg::PERIOD_W-1:0]     cfg_wdata_i,
  input  logic                              command_i,
  input  logic [btum_pkg::OUT_W-1:0]        timestamp_us_i,
  output logic [btum_pkg::OUT_W-1:0]        wait_time_us_o,
  output logic [btum_pkg::OUT_W-1:0]        busy_time_us_o,
  output logic [btum_pkg::OUT_W-1:0]        elapsed_time_us_o,
  output logic [btum_pkg::HUND_W-1:0]       busy_hundredths_o
);

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? '1 : s[TW-1:0];
  endfunction

  // Architectural state
  logic [btum_pkg::PERIOD_W-1:0] period_q;
  logic [TW-1:0] last_start_q, last_stop_q, win_start_q, wait_sum_q, busy_sum_q;

  // Working registers
  logic                  cmd_q;
  logic [TW-1:0]         ts_q, diff_q;
  logic [TW:0]           win_end_q;
  logic [TW-1:0]         wt_q, bz_q, el_q, rem_q;
  logic [btum_pkg::QUO_W-1:0]  quo_q;
  logic [btum_pkg::CNT_W-1:0]  cnt_q;
  logic [btum_pkg::HUND_W-1:0] hund_q;

  logic [TW-1:0] ref_time;
  logic [TW-1:0] mod_x, rem_d;
  logic [TW:0]   mod_s;
  logic          mod_wrap;
  logic          el_zero, bz_full;
  logic [btum_pkg::QUO_W-1:0] quo_rnd;

  assign ref_time = (cmd_q == btum_pkg::CMD_WAIT_END) ? last_start_q : last_stop_q;

  // Shared add-mod step: rem = (rem + x) mod elapsed
  assign mod_x    = cmd_i.dbl ? rem_q : bz_q;
  assign mod_s    = {1'b0, rem_q} + {1'b0, mod_x};
  assign mod_wrap = (mod_s >= {1'b0, el_q});
  assign rem_d    = mod_wrap ? TW'(mod_s - {1'b0, el_q}) : mod_s[TW-1:0];

  assign el_zero = (el_q == '0);
  assign bz_full = (bz_q >= el_q);
  assign quo_rnd = quo_q + btum_pkg::QUO_W'(1);

  assign sts_o.is_stop   = (cmd_q == btum_pkg::CMD_WAIT_END);
  assign sts_o.due       = !win_end_q[TW] && (win_end_q[TW-1:0] < ts_q);
  assign sts_o.trivial   = el_zero || bz_full;
  assign sts_o.scale_bit = btum_pkg::SCALE2[cnt_q];
  assign sts_o.last_bit  = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= btum_pkg::PERIOD_RESET;
      last_start_q <= '0;
      last_stop_q  <= '0;
      win_start_q  <= '0;
      wait_sum_q   <= '0;
      busy_sum_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (cmd_i.accum) begin
        if (cmd_q == btum_pkg::CMD_WAIT_END) begin
          wait_sum_q  <= sat_add(wait_sum_q, diff_q);
          last_stop_q <= ts_q;
        end else begin
          busy_sum_q   <= sat_add(busy_sum_q, diff_q);
          last_start_q <= ts_q;
          if (win_start_q == '0) begin
            win_start_q <= ts_q;
          end
        end
      end
      if (cmd_i.report) begin
        wait_sum_q  <= '0;
        busy_sum_q  <= '0;
        win_start_q <= win_end_q[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= command_i;
      ts_q  <= TW'(timestamp_us_i);
    end
    if (cmd_i.diff) begin
      // never-set reference or time going back adds nothing
      diff_q    <= (ref_time != '0 && ts_q > ref_time) ? ts_q - ref_time : '0;
      win_end_q <= {1'b0, win_start_q} + (TW+1)'(period_q);
    end
    if (cmd_i.report) begin
      wt_q <= wait_sum_q;
      bz_q <= busy_sum_q;
      el_q <= sat_add(wait_sum_q, busy_sum_q);
    end
    if (cmd_i.classify) begin
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= btum_pkg::CNT_W'(btum_pkg::SCALE_BITS - 1);
      if (el_zero) begin
        hund_q <= '0;
      end else if (bz_full) begin
        hund_q <= btum_pkg::HUND_FULL;
      end
    end
    if (cmd_i.dbl) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[btum_pkg::QUO_W-2:0], 1'b0} + btum_pkg::QUO_W'(mod_wrap);
      if (!sts_o.scale_bit) begin
        cnt_q <= cnt_q - btum_pkg::CNT_W'(1);
      end
    end
    if (cmd_i.add) begin
      rem_q <= rem_d;
      quo_q <= quo_q + btum_pkg::QUO_W'(mod_wrap);
      cnt_q <= cnt_q - btum_pkg::CNT_W'(1);
    end
    if (cmd_i.finish) begin
      hund_q <= quo_rnd[btum_pkg::HUND_W:1];
    end
  end

  assign wait_time_us_o    = btum_pkg::OUT_W'(wt_q);
  assign busy_time_us_o    = btum_pkg::OUT_W'(bz_q);
  assign elapsed_time_us_o = btum_pkg::OUT_W'(el_q);
  assign busy_hundredths_o = hund_q;

endmodule
